// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising aclk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising aclk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/aesc_pkg.sv =====
// Package: AES types, constant tables and round functions.
`default_nettype none
package aesc_pkg;

    localparam int MAX_ROUNDS_DEF = 14;
    localparam int KX_IDX_W       = 6;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_A   = 3'd0;
    localparam logic [2:0] REG_KEY_B   = 3'd1;
    localparam logic [2:0] REG_KEY_C   = 3'd2;
    localparam logic [2:0] REG_KEY_D   = 3'd3;
    localparam logic [2:0] REG_KEY_LEN = 3'd4;
    localparam logic [2:0] REG_DECRYPT = 3'd5;

    typedef logic [7:0] sbox_tab_t [0:255];

    // one key schedule word written to the round key registers
    typedef struct packed {
        logic                en;
        logic                done;
        logic [KX_IDX_W-1:0] idx;
        logic [31:0]         word;
    } kx_wr_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x   = {1'b0, a};
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x = x ^ 9'h11b;
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r    = 8'h01;
        base = x;
        e    = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = gf_mul(r, base);
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        logic [15:0] d;
        d = {x, x} << n;
        return d[15:8];
    endfunction

    function automatic sbox_tab_t build_sbox();
        sbox_tab_t  t;
        logic [7:0] b;
        for (int i = 0; i < 256; i++) begin
            b    = gf_inv(8'(i));
            t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
        end
        return t;
    endfunction

    function automatic sbox_tab_t build_dec_sbox();
        sbox_tab_t  t;
        logic [7:0] b;
        for (int i = 0; i < 256; i++) begin
            b    = rotl8(8'(i), 1) ^ rotl8(8'(i), 3) ^ rotl8(8'(i), 6) ^ 8'h05;
            t[i] = gf_inv(b);
        end
        return t;
    endfunction

    localparam sbox_tab_t SBOX     = build_sbox();
    localparam sbox_tab_t DEC_SBOX = build_dec_sbox();

    // state byte k (row k%4, column k/4) sits at bits 127-8k downward
    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int k = 0; k < 16; k++)
            t[127-8*k -: 8] = inv ? DEC_SBOX[s[127-8*k -: 8]] : SBOX[s[127-8*k -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int           o;
        int           d;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                o = r + 4 * ((c + r) % 4);
                d = r + 4 * c;
                if (inv) t[127-8*o -: 8] = s[127-8*d -: 8];
                else     t[127-8*d -: 8] = s[127-8*o -: 8];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   m [0:3];
        logic [7:0]   v;
        if (inv) begin
            m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
        end else begin
            m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int j = 0; j < 4; j++)
                    v = v ^ gf_mul(m[(j - r + 4) % 4], s[127-8*(4*c+j) -: 8]);
                t[127-8*(4*c+r) -: 8] = v;
            end
        return t;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_block_cipher.sv =====
// Top level: AES-128/192/256 block cipher, one round per pipeline stage.
`default_nettype none
`include "assert_macros.svh"
//
// Channel   Direction  Ports                        Contents (low bits first)
// s_        in         s_tvalid s_tready s_tdata    block_high, block_low
// m_        out        m_tvalid m_tready m_tdata    result_high, result_low
// cfg_      in         cfg_valid cfg_ready          cfg_index, cfg_data
//
// Throughput one block per cycle while s_tready is high; the pipeline is a key add
// stage plus one stage per round up to MAX_ROUNDS, unused rounds pass through.
// After reset or any key / key length write the schedule runs one word per
// cycle after a start cycle, 4*(Nr+1) words in all; s_tready stays low meanwhile.
// The whole pipeline holds while the output transfer is stalled.
// Reset is synchronous, active low; round key registers are not cleared.
module aes_block_cipher #(
    parameter int MAX_ROUNDS = aesc_pkg::MAX_ROUNDS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // [63:0] block_high, [127:64] block_low
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // [63:0] result_high, [127:64] result_low
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    localparam int WIDX_W = $clog2(4 * (MAX_ROUNDS + 1));
    localparam int RK_W   = WIDX_W - 2;
    localparam int NR_W   = $clog2(MAX_ROUNDS + 1);

    // configuration registers
    logic [63:0] key_reg [0:3];
    logic [1:0]  len_reg;
    logic        dec_reg;
    logic        keys_ready_reg;
    logic        cfg_wr;
    logic        cfg_key_wr;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign cfg_key_wr = cfg_wr && cfg_index <= aesc_pkg::REG_KEY_LEN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) key_reg[k] <= '0;
            len_reg <= 2'd0;
            dec_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_index)
                aesc_pkg::REG_KEY_A:   key_reg[0] <= cfg_data;
                aesc_pkg::REG_KEY_B:   key_reg[1] <= cfg_data;
                aesc_pkg::REG_KEY_C:   key_reg[2] <= cfg_data;
                aesc_pkg::REG_KEY_D:   key_reg[3] <= cfg_data;
                aesc_pkg::REG_KEY_LEN: len_reg    <= cfg_data[1:0];
                aesc_pkg::REG_DECRYPT: dec_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // round count: length code three acts as 256-bit
    logic [1:0]      len_code;
    logic [4:0]      nr_raw;
    logic [NR_W-1:0] nr;
    logic [3:0]      nk;
    logic [WIDX_W-1:0] last_word;

    assign len_code  = (len_reg == 2'd3) ? 2'd2 : len_reg;
    assign nr_raw    = 5'd10 + {2'b0, len_code, 1'b0};
    assign nr        = (nr_raw > 5'(MAX_ROUNDS)) ? NR_W'(MAX_ROUNDS) : NR_W'(nr_raw);
    assign nk        = 4'd4 + {1'b0, len_code, 1'b0};
    assign last_word = WIDX_W'({nr, 2'b11});

    // key schedule
    aesc_pkg::kx_wr_t kx_wr;
    logic             kx_busy;
    logic             kx_start;

    assign kx_start = !keys_ready_reg && !kx_busy && !cfg_key_wr;

    aesc_key_expand #(.MAX_ROUNDS(MAX_ROUNDS)) u_kx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (kx_start),
        .abort_i (cfg_key_wr),
        .key_i   ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .nk_i    (nk),
        .last_i  (last_word),
        .wr_o    (kx_wr),
        .busy_o  (kx_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_ready_reg <= 1'b0;
        end else if (cfg_key_wr) begin
            keys_ready_reg <= 1'b0;
        end else if (kx_wr.done) begin
            keys_ready_reg <= 1'b1;
        end
    end

    // round keys, one 128-bit register per round
    logic [127:0]      rk_reg [0:MAX_ROUNDS];
    logic [RK_W-1:0]   wr_round;
    logic [1:0]        wr_lane;

    assign wr_round = kx_wr.idx[RK_W+1:2];
    assign wr_lane  = kx_wr.idx[1:0];

    always_ff @(posedge aclk) begin
        if (kx_wr.en) rk_reg[wr_round][(3 - wr_lane) * 32 +: 32] <= kx_wr.word;
    end

    // pipeline
    logic         advance;
    logic         in_xfer;
    logic         vld [0:MAX_ROUNDS];
    logic [127:0] st  [0:MAX_ROUNDS];
    logic         v0_reg;
    logic [127:0] s0_reg;
    logic [127:0] blk;

    assign advance  = !vld[MAX_ROUNDS] || m_tready;
    assign s_tready = keys_ready_reg && advance;
    assign in_xfer  = s_tvalid && s_tready;
    assign blk      = {s_tdata[63:0], s_tdata[127:64]};

    // stage 0: initial key add (last round key when decrypting)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= in_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) s0_reg <= blk ^ rk_reg[dec_reg ? RK_W'(nr) : RK_W'(0)];
    end

    assign vld[0] = v0_reg;
    assign st[0]  = s0_reg;

    for (genvar j = 1; j <= MAX_ROUNDS; j++) begin : g_round
        logic [127:0]    key;
        logic [NR_W-1:0] dec_idx;

        assign dec_idx = (nr >= NR_W'(j)) ? nr - NR_W'(j) : '0;
        assign key     = dec_reg ? rk_reg[RK_W'(dec_idx)] : rk_reg[j];

        aesc_round #(.STAGE(j), .NR_W(NR_W)) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance_i (advance),
            .valid_i   (vld[j-1]),
            .state_i   (st[j-1]),
            .decrypt_i (dec_reg),
            .nr_i      (nr),
            .key_i     (key),
            .valid_o   (vld[j]),
            .state_o   (st[j])
        );
    end

    assign m_tvalid = vld[MAX_ROUNDS];
    assign m_tdata  = {st[MAX_ROUNDS][63:0], st[MAX_ROUNDS][127:64]};

    `ASSERT_CLK(a_in_needs_keys, in_xfer |-> keys_ready_reg && !kx_busy, "block taken before round keys complete")
    `ASSERT_CLK(a_busy_not_ready, kx_busy |-> !keys_ready_reg, "schedule running while keys marked ready")
    `ASSERT_CLK(a_key_wr_clears, cfg_key_wr |=> !keys_ready_reg, "key write did not clear ready")
    `ASSERT_CLK(a_stall_holds, !advance |=> $stable(m_tdata) && m_tvalid, "stalled result changed")

endmodule
`default_nettype wire

// ===== rtl/aesc_key_expand.sv =====
// Key schedule: one 32-bit schedule word per cycle.
`default_nettype none
module aesc_key_expand #(
    parameter int MAX_ROUNDS = aesc_pkg::MAX_ROUNDS_DEF,
    localparam int WIDX_W    = $clog2(4 * (MAX_ROUNDS + 1))
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start_i,
    input  wire logic                 abort_i,
    input  wire logic [255:0]         key_i,
    input  wire logic [3:0]           nk_i,
    input  wire logic [WIDX_W-1:0]    last_i,
    output aesc_pkg::kx_wr_t          wr_o,
    output logic                      busy_o
);

    logic              busy_reg;
    logic [WIDX_W-1:0] idx_reg;
    logic [2:0]        mod_reg;
    logic [7:0]        rcon_reg;
    logic [31:0]       win_reg [0:7];
    logic [31:0]       word;
    logic [31:0]       t;
    logic              from_key;
    logic [2:0]        back;

    assign from_key = idx_reg < WIDX_W'(nk_i);
    assign back     = 3'(nk_i - 4'd1);

    always_comb begin
        t = win_reg[0];
        if (mod_reg == 3'd0) begin
            t = aesc_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_reg, 24'h0};
        end else if (nk_i == 4'd8 && mod_reg == 3'd4) begin
            t = aesc_pkg::sub_word(t);
        end
        if (from_key) word = key_i[(7 - idx_reg[2:0]) * 32 +: 32];
        else          word = t ^ win_reg[back];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (abort_i) begin
            busy_reg <= 1'b0;
        end else if (start_i) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && idx_reg == last_i) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            idx_reg  <= '0;
            mod_reg  <= 3'd0;
            rcon_reg <= 8'h01;
        end else if (busy_reg) begin
            idx_reg <= idx_reg + 1'b1;
            mod_reg <= (mod_reg == back) ? 3'd0 : mod_reg + 3'd1;
            if (!from_key && mod_reg == 3'd0) rcon_reg <= aesc_pkg::xtime(rcon_reg);
            win_reg[0] <= word;
            for (int k = 1; k < 8; k++) win_reg[k] <= win_reg[k-1];
        end
    end

    assign wr_o.en   = busy_reg && !abort_i;
    assign wr_o.done = busy_reg && !abort_i && idx_reg == last_i;
    assign wr_o.idx  = aesc_pkg::KX_IDX_W'(idx_reg);
    assign wr_o.word = word;
    assign busy_o    = busy_reg;

endmodule
`default_nettype wire

// ===== rtl/aesc_round.sv =====
// One cipher round stage of the pipeline, encrypt or decrypt.
`default_nettype none
module aesc_round #(
    parameter int STAGE = 1,
    parameter int NR_W  = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance_i,
    input  wire logic            valid_i,
    input  wire logic [127:0]    state_i,
    input  wire logic            decrypt_i,
    input  wire logic [NR_W-1:0] nr_i,
    input  wire logic [127:0]    key_i,
    output logic                 valid_o,
    output logic [127:0]         state_o
);

    logic         valid_reg;
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] t;
    logic         active;
    logic         final_rnd;

    assign active    = NR_W'(STAGE) <= nr_i;
    assign final_rnd = NR_W'(STAGE) == nr_i;

    always_comb begin
        if (!decrypt_i) begin
            t = aesc_pkg::shift_rows(aesc_pkg::sub_bytes(state_i, 1'b0), 1'b0);
            if (!final_rnd) t = aesc_pkg::mix_columns(t, 1'b0);
            t = t ^ key_i;
        end else begin
            t = aesc_pkg::sub_bytes(aesc_pkg::shift_rows(state_i, 1'b1), 1'b1) ^ key_i;
            if (!final_rnd) t = aesc_pkg::mix_columns(t, 1'b1);
        end
        state_next = active ? t : state_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance_i) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_i) state_reg <= state_next;
    end

    assign valid_o = valid_reg;
    assign state_o = state_reg;

endmodule
`default_nettype wire
